### src/scac_pkg.sv
// Shared types and constants for the subtitle coverage ARGB compositor.
// No dependencies; imported by scac_out_fifo, the compositor top level and the testbench.
package scac_pkg;

    // operation codes
    localparam logic [1:0] OP_BLEND = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_LEFT   = 2'd0;
    localparam logic [1:0] CFG_TOP    = 2'd1;
    localparam logic [1:0] CFG_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_HEIGHT = 2'd3;

    localparam int CFG_DATA_W  = 16;
    localparam int DIM_W       = 9;             // canvas width / height registers
    localparam int ADDR_FULL_W = 2 * DIM_W;     // row * pitch + column
    localparam int POS_W       = 16;
    localparam int REL_W       = POS_W + 1;     // position minus origin

    localparam logic [31:0] TRANSPARENT_PIXEL = 32'hff00_0000;
    localparam logic [DIM_W-1:0] DIM_RESET    = 9'd256;

    // result queue depth; covers every word in flight plus slack
    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic [31:0] pixel;
        logic        in_bounds;
    } t_result;

endpackage

### src/scac_blend.sv
// Pixel blend datapath: glyph color over a stored inverted-alpha ARGB pixel.
// Purely combinational; the source alpha is computed upstream.
module scac_blend (
    input  logic [31:0] i_dest,
    input  logic [7:0]  i_src_alpha,
    input  logic [31:0] i_glyph_color,
    output logic [31:0] o_pixel
);

    logic [7:0]  comp;
    logic [15:0] alpha_prod;
    logic [7:0]  alpha_sum;
    logic [16:0] sum_r;
    logic [16:0] sum_g;
    logic [16:0] sum_b;

    assign comp = 8'hff - i_src_alpha;

    // opacity of destination weighted by complement, then inverted back
    assign alpha_prod = 16'(8'hff - i_dest[31:24]) * 16'(comp);
    assign alpha_sum  = i_src_alpha + alpha_prod[15:8];

    assign sum_r = 17'(16'(i_glyph_color[31:24]) * 16'(i_src_alpha))
                 + 17'(16'(i_dest[23:16]) * 16'(comp));
    assign sum_g = 17'(16'(i_glyph_color[23:16]) * 16'(i_src_alpha))
                 + 17'(16'(i_dest[15:8]) * 16'(comp));
    assign sum_b = 17'(16'(i_glyph_color[15:8]) * 16'(i_src_alpha))
                 + 17'(16'(i_dest[7:0]) * 16'(comp));

    assign o_pixel = {8'hff - alpha_sum, sum_r[15:8], sum_g[15:8], sum_b[15:8]};

endmodule

### src/scac_out_fifo.sv
// Result queue between the compositor pipeline and the output channel.
// Depends on scac_pkg for the result type and depth.
module scac_out_fifo
    import scac_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_push_data,
    input  logic    i_pop,
    output logic    o_valid,
    output t_result o_data
);

    t_result              r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr_ptr;
    logic [OUT_PTR_W-1:0] r_rd_ptr;
    logic [OUT_CNT_W-1:0] r_count;
    logic                 pop_ok;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + OUT_CNT_W'(i_push) - OUT_CNT_W'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // upstream credit must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == OUT_CNT_W'(OUT_DEPTH)) |-> (!i_push || pop_ok))
        else $error("result queue overflow");

endmodule

### src/subtitle_coverage_argb_compositor.sv
// Top level of the subtitle coverage ARGB compositor: canvas memory, pipeline, config.
// Depends on scac_pkg, scac_blend and scac_out_fifo.
//
//  channel   direction  handshake                     word
//  in        sink       i_in_valid / o_in_ready       operation, pos_x, pos_y, coverage, color
//  out       source     o_out_valid / i_out_ready     pixel, in_bounds
//  cfg       sink       i_cfg_we (no wait)            i_cfg_idx, i_cfg_data
//
//  One word per cycle sustained while the result queue has credit. A word's result
//  passes origin offset, bounds/address and memory read; blend and write-back then
//  push it into the result queue, from which the output can take it.
//  The canvas memory does one read and one write per cycle; a write-back in the same
//  cycle as a read of the same pixel is forwarded.
//  After reset a clearing pass writes every canvas pixel (MAX_WIDTH*MAX_HEIGHT, 65536
//  by default) to transparent, one per cycle; no word is accepted meanwhile. A stalled
//  output fills the result queue; input then waits on credit.
module subtitle_coverage_argb_compositor
    import scac_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // input words
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_operation,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic [7:0]             i_coverage,
    input  logic [31:0]            i_glyph_color,
    // result words
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [31:0]            o_pixel,
    output logic                   o_in_bounds
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [POS_W-1:0] r_cfg_left;
    logic signed [POS_W-1:0] r_cfg_top;
    logic [DIM_W-1:0]        r_cfg_width;
    logic [DIM_W-1:0]        r_cfg_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_left   <= '0;
            r_cfg_top    <= '0;
            r_cfg_width  <= DIM_RESET;
            r_cfg_height <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LEFT:   r_cfg_left   <= i_cfg_data;
                CFG_TOP:    r_cfg_top    <= i_cfg_data;
                CFG_WIDTH:  r_cfg_width  <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT: r_cfg_height <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // width / height saturated to the store's geometry
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;

    assign w_eff = (int'(r_cfg_width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : r_cfg_width;
    assign h_eff = (int'(r_cfg_height) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : r_cfg_height;

    // ------------------------------------------------------------------
    // clearing pass and credit
    // ------------------------------------------------------------------
    logic                 r_clr_busy;
    logic [AW-1:0]        r_clr_addr;
    logic [OUT_CNT_W-1:0] r_occ;      // accepted, not yet delivered
    logic                 in_acc;
    logic                 out_acc;

    assign o_in_ready = !r_clr_busy && (r_occ != OUT_CNT_W'(OUT_DEPTH));
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_acc    = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_occ      <= '0;
        end else begin
            if (r_clr_busy) begin
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            r_occ <= r_occ + OUT_CNT_W'(in_acc) - OUT_CNT_W'(out_acc);
        end
    end

    // ------------------------------------------------------------------
    // stage A: position relative to canvas origin
    // ------------------------------------------------------------------
    logic                    r_a_valid;
    logic [1:0]              r_a_op;
    logic signed [REL_W-1:0] r_a_rx;
    logic signed [REL_W-1:0] r_a_ry;
    logic [7:0]              r_a_cov;
    logic [31:0]             r_a_color;

    // stage B: address and memory read
    logic                    r_b_valid;
    logic [1:0]              r_b_op;
    logic                    r_b_inb;
    logic [AW-1:0]           r_b_addr;
    logic [7:0]              r_b_s;
    logic [31:0]             r_b_color;

    // stage C: blend and write-back
    logic                    r_c_valid;
    logic [1:0]              r_c_op;
    logic                    r_c_inb;
    logic [AW-1:0]           r_c_addr;
    logic [7:0]              r_c_s;
    logic [31:0]             r_c_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= in_acc;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_op    <= i_operation;
        r_a_rx    <= REL_W'(i_pos_x) - REL_W'(r_cfg_left);
        r_a_ry    <= REL_W'(i_pos_y) - REL_W'(r_cfg_top);
        r_a_cov   <= i_coverage;
        r_a_color <= i_glyph_color;
    end

    // bounds, row address and source alpha
    logic                   a_inb;
    logic [ADDR_FULL_W-1:0] a_addr_full;
    logic [15:0]            a_alpha_prod;

    assign a_inb = !r_a_rx[REL_W-1] && !r_a_ry[REL_W-1]
                && (r_a_rx[POS_W-1:0] < POS_W'(w_eff))
                && (r_a_ry[POS_W-1:0] < POS_W'(h_eff));
    // inside the canvas the address stays below w*h, never past the store
    assign a_addr_full = (ADDR_FULL_W'(r_a_ry[DIM_W-1:0]) * ADDR_FULL_W'(w_eff))
                       + ADDR_FULL_W'(r_a_rx[DIM_W-1:0]);
    // coverage scaled by glyph opacity (AA is transparency)
    assign a_alpha_prod = 16'(r_a_cov) * 16'(8'hff - r_a_color[7:0]);

    always_ff @(posedge i_clk) begin
        r_b_op    <= r_a_op;
        r_b_inb   <= a_inb;
        r_b_addr  <= AW'(a_addr_full);
        r_b_s     <= a_alpha_prod[15:8];
        r_b_color <= r_a_color;
        r_c_op    <= r_b_op;
        r_c_inb   <= r_b_inb;
        r_c_addr  <= r_b_addr;
        r_c_s     <= r_b_s;
        r_c_color <= r_b_color;
    end

    // ------------------------------------------------------------------
    // canvas memory: read in stage B, written in stage C or by the clear pass
    // ------------------------------------------------------------------
    logic [31:0]   r_canvas [DEPTH];
    logic [31:0]   r_mem_q;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic          c_we;
    logic [31:0]   c_pix;

    assign mem_we    = r_clr_busy || c_we;
    assign mem_waddr = r_clr_busy ? r_clr_addr : r_c_addr;
    assign mem_wdata = r_clr_busy ? TRANSPARENT_PIXEL : c_pix;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_canvas[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= r_canvas[r_b_addr];
    end

    // the write in the same cycle as our read is missed by the memory
    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_addr;
    logic [31:0]   r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= c_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_addr <= r_c_addr;
        r_fwd_data <= c_pix;
    end

    // ------------------------------------------------------------------
    // stage C: merge, blend, write-back
    // ------------------------------------------------------------------
    logic [31:0] c_dest;
    logic [31:0] c_blended;
    t_result     c_result;

    assign c_dest = (r_fwd_valid && (r_fwd_addr == r_c_addr)) ? r_fwd_data : r_mem_q;

    scac_blend u_blend (
        .i_dest        (c_dest),
        .i_src_alpha   (r_c_s),
        .i_glyph_color (r_c_color),
        .o_pixel       (c_blended)
    );

    always_comb begin
        case (r_c_op)
            OP_BLEND: begin
                c_pix = c_blended;
                c_we  = r_c_valid && r_c_inb;
            end
            OP_CLEAR: begin
                c_pix = TRANSPARENT_PIXEL;
                c_we  = r_c_valid && r_c_inb;
            end
            default: begin          // read, and the unused code
                c_pix = c_dest;
                c_we  = 1'b0;
            end
        endcase
    end

    assign c_result.pixel     = r_c_inb ? c_pix : 32'd0;
    assign c_result.in_bounds = r_c_inb;

    // ------------------------------------------------------------------
    // result queue
    // ------------------------------------------------------------------
    t_result out_word;

    scac_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_c_valid),
        .i_push_data (c_result),
        .i_pop       (i_out_ready),
        .o_valid     (o_out_valid),
        .o_data      (out_word)
    );

    assign o_pixel     = out_word.pixel;
    assign o_in_bounds = out_word.in_bounds;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_in_ready)
        else $error("word accepted during clearing pass");

    a_oob_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_in_bounds) |-> (o_pixel == 32'd0))
        else $error("out-of-bounds result carries a pixel");

    a_credit_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid || r_b_valid || r_c_valid) |-> (r_occ != '0))
        else $error("word in flight without credit");

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OUT_CNT_W'(OUT_DEPTH))
        else $error("credit count past queue depth");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for subtitle_coverage_argb_compositor: blend, read and clear words
// against a canvas predictor kept in the bench. Depends on scac_pkg and the compositor RTL.
module tb
    import scac_pkg::*;
();

    localparam int         CANVAS_WORDS = 65536;
    localparam int         MAX_DIM      = 256;
    localparam int         DRAIN_CYCLES = 8;       // pipeline flush margin after the last result
    localparam int         CYCLE_LIMIT  = 500000;  // clearing pass plus worst-case gaps, x4
    localparam logic [1:0] OP_SPARE     = 2'd3;    // unused code, behaves as a read

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [1:0]             i_cfg_idx     = CFG_LEFT;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   i_in_valid    = 1'b0;
    logic                   o_in_ready;
    logic [1:0]             i_operation   = OP_READ;
    logic signed [POS_W-1:0] i_pos_x      = '0;
    logic signed [POS_W-1:0] i_pos_y      = '0;
    logic [7:0]             i_coverage    = '0;
    logic [31:0]            i_glyph_color = '0;
    logic                   o_out_valid;
    logic                   i_out_ready   = 1'b0;
    logic [31:0]            o_pixel;
    logic                   o_in_bounds;

    // predictor state: canvas copy and register copies
    logic [31:0]             canvas_model [CANVAS_WORDS];
    logic signed [15:0]      model_left;
    logic signed [15:0]      model_top;
    logic [DIM_W-1:0]        model_width;
    logic [DIM_W-1:0]        model_height;

    t_result                 pending_results [$];
    int                      error_count = 0;
    int                      cycle_count = 0;
    bit                      no_idle     = 1'b0;   // both sides run back to back when set

    subtitle_coverage_argb_compositor u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_coverage    (i_coverage),
        .i_glyph_color (i_glyph_color),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel       (o_pixel),
        .o_in_bounds   (o_in_bounds)
    );

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d words still pending", $time, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // glyph color over stored pixel; alpha bytes are transparency, not opacity
    function automatic logic [31:0] composite_over(input logic [31:0] dest,
                                                   input logic [7:0]  cov,
                                                   input logic [31:0] color);
        int src_a, comp_a, dest_a, out_a, red, grn, blu;
        src_a  = (int'(cov) * (255 - int'(color[7:0]))) >> 8;
        comp_a = 255 - src_a;
        dest_a = int'(dest[31:24]);
        out_a  = 255 - (src_a + (((255 - dest_a) * comp_a) >> 8));
        // each channel keeps bits 15:8 of the weighted sum
        red = int'(color[31:24]) * src_a + int'(dest[23:16]) * comp_a;
        grn = int'(color[23:16]) * src_a + int'(dest[15:8]) * comp_a;
        blu = int'(color[15:8])  * src_a + int'(dest[7:0])   * comp_a;
        return {out_a[7:0], red[15:8], grn[15:8], blu[15:8]};
    endfunction

    // applies one accepted word to the canvas copy and returns its result word
    function automatic t_result apply_word(input logic [1:0]         op,
                                           input logic signed [15:0] x,
                                           input logic signed [15:0] y,
                                           input logic [7:0]         cov,
                                           input logic [31:0]        color);
        int      w, h, rx, ry, addr;
        t_result res;
        w  = (int'(model_width)  > MAX_DIM) ? MAX_DIM : int'(model_width);
        h  = (int'(model_height) > MAX_DIM) ? MAX_DIM : int'(model_height);
        rx = int'(x) - int'(model_left);
        ry = int'(y) - int'(model_top);
        res.pixel     = '0;
        res.in_bounds = 1'b0;
        if (rx < 0 || ry < 0 || rx >= w || ry >= h)
            return res;
        addr = ry * w + rx;
        res.pixel     = canvas_model[addr];
        res.in_bounds = 1'b1;
        case (op)
            OP_BLEND: begin
                res.pixel = composite_over(canvas_model[addr], cov, color);
                canvas_model[addr] = res.pixel;
            end
            OP_CLEAR: begin
                res.pixel = TRANSPARENT_PIXEL;
                canvas_model[addr] = res.pixel;
            end
            default: ;   // read and spare code leave the canvas alone
        endcase
        return res;
    endfunction

    // one input word: random gap, then valid held until accepted
    task automatic send_word(input logic [1:0]         op,
                             input logic signed [15:0] x,
                             input logic signed [15:0] y,
                             input logic [7:0]         cov,
                             input logic [31:0]        color);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        repeat (gap) @(negedge i_clk) i_in_valid <= 1'b0;
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_pos_x       <= x;
        i_pos_y       <= y;
        i_coverage    <= cov;
        i_glyph_color <= color;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(apply_word(op, x, y, cov, color));
    endtask

    // input quiet, every result in, pipeline flushed
    task automatic wait_idle();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk) i_cfg_we <= 1'b0;
        case (idx)
            CFG_LEFT:   model_left   = data;
            CFG_TOP:    model_top    = data;
            CFG_WIDTH:  model_width  = data[DIM_W-1:0];
            CFG_HEIGHT: model_height = data[DIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_canvas(input logic [15:0] left, input logic [15:0] top,
                              input logic [15:0] width, input logic [15:0] height);
        wait_idle();
        write_reg(CFG_LEFT, left);
        write_reg(CFG_TOP, top);
        write_reg(CFG_WIDTH, width);
        write_reg(CFG_HEIGHT, height);
    endtask

    // every operation at reset geometry, corners, out of bounds, field extremes
    task automatic test_directed_ops();
        send_word(OP_READ,  0, 0, 8'd0, 32'h0);
        send_word(OP_BLEND, 0, 0, 8'd255, 32'h1234_5600);   // opaque glyph, full coverage
        send_word(OP_BLEND, 0, 0, 8'd128, 32'habcd_ef40);
        send_word(OP_BLEND, 0, 0, 8'd0,   32'hffff_ff00);   // no coverage
        send_word(OP_BLEND, 0, 0, 8'd255, 32'h0000_00ff);   // fully transparent glyph
        send_word(OP_READ,  0, 0, 8'd0, 32'h0);
        send_word(OP_BLEND, 255, 255, 8'd255, 32'hffff_ff00);
        send_word(OP_BLEND, 255, 255, 8'd255, 32'h0000_0000);
        send_word(OP_SPARE, 255, 255, 8'd255, 32'hffff_ffff);
        send_word(OP_CLEAR, 255, 255, 8'd0, 32'h0);
        send_word(OP_READ,  255, 255, 8'd0, 32'h0);
        // out of bounds on each side
        send_word(OP_BLEND, -1, 0, 8'd255, 32'h5555_5500);
        send_word(OP_READ,  0, -1, 8'd0, 32'h0);
        send_word(OP_CLEAR, 256, 3, 8'd0, 32'h0);
        send_word(OP_BLEND, 3, 256, 8'd255, 32'haaaa_aa00);
        send_word(OP_READ,  -32768, -32768, 8'd0, 32'h0);
        send_word(OP_BLEND, 32767, 32767, 8'd255, 32'hffff_ffff);
        send_word(OP_CLEAR, 0, 0, 8'd0, 32'h0);
        send_word(OP_READ,  0, 0, 8'd0, 32'h0);
    endtask

    // origin at the position extremes, 1x1 canvas, zero width, oversized dimensions
    task automatic test_config_extremes();
        set_canvas(16'h8000, 16'h7fff, 16'd1, 16'd1);
        send_word(OP_BLEND, -32768, 32767, 8'd255, 32'h1122_3300);
        send_word(OP_READ,  -32768, 32767, 8'd0, 32'h0);
        send_word(OP_BLEND, -32767, 32767, 8'd255, 32'h1122_3300);
        send_word(OP_READ,  -32768, 32766, 8'd0, 32'h0);
        wait_idle();
        write_reg(CFG_WIDTH, 16'd0);
        send_word(OP_READ,  -32768, 32767, 8'd0, 32'h0);
        // width 511 and height 300 saturate to 256
        set_canvas(-16'sd100, -16'sd100, 16'hffff, 16'd300);
        send_word(OP_BLEND, 155, 155, 8'd200, 32'h8040_2010);
        send_word(OP_BLEND, 156, 0, 8'd200, 32'h8040_2010);
        send_word(OP_READ,  155, -100, 8'd0, 32'h0);
        send_word(OP_READ,  155, 155, 8'd0, 32'h0);
    endtask

    // mostly in-canvas words with a hot corner so blends pile up; the rest edge and noise
    task automatic run_random_phase(input int count);
        int                 w, h, k, pick, rx, ry;
        logic [1:0]         op;
        logic signed [15:0] x, y;
        logic [7:0]         cov;
        logic [31:0]        color;
        w = (int'(model_width)  > MAX_DIM) ? MAX_DIM : int'(model_width);
        h = (int'(model_height) > MAX_DIM) ? MAX_DIM : int'(model_height);
        for (k = 0; k < count; k++) begin
            if (k % 50 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                rx = $urandom_range(0, 1) ? $urandom_range(0, (w < 8 ? w : 8) - 1)
                                          : $urandom_range(0, w - 1);
                ry = $urandom_range(0, 1) ? $urandom_range(0, (h < 8 ? h : 8) - 1)
                                          : $urandom_range(0, h - 1);
            end else if (pick < 90) begin
                rx = $urandom_range(0, 1) ? w : -1;
                ry = $urandom_range(0, 1) ? $urandom_range(0, h - 1) : h;
            end else begin
                rx = 0;
                ry = 0;
            end
            if (pick < 90) begin
                x = 16'(int'(model_left) + rx);
                y = 16'(int'(model_top) + ry);
            end else begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)      op = OP_BLEND;
            else if (pick < 75) op = OP_READ;
            else if (pick < 88) op = OP_CLEAR;
            else                op = OP_SPARE;
            case ($urandom_range(0, 3))
                0:       cov = 8'd255;
                1:       cov = 8'd0;
                default: cov = 8'($urandom);
            endcase
            color = $urandom;
            if ($urandom_range(0, 3) == 0)
                color[7:0] = 8'h00;
            send_word(op, x, y, cov, color);
        end
    endtask

    task automatic test_random_traffic();
        set_canvas(16'd0, 16'd0, 16'd256, 16'd256);
        run_random_phase(500);
        set_canvas(-16'sd20, 16'd37, 16'd16, 16'd9);
        run_random_phase(350);
        set_canvas(16'($urandom), 16'($urandom), 16'($urandom_range(1, 40)),
                   16'($urandom_range(1, 40)));
        run_random_phase(350);
        set_canvas(16'd32704, 16'h8000, 16'd64, 16'd64);
        run_random_phase(300);
        // upper data bits dropped: height 2, width 300 saturates
        set_canvas(16'd5, -16'sd3, 16'd300, 16'h0e02);
        run_random_phase(300);
    endtask

    // result side: random stall per word, ready then held until a word is taken
    initial begin : drain_results
        int stall;
        wait (i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            repeat (stall) @(negedge i_clk) i_out_ready <= 1'b0;
            @(negedge i_clk) i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // compare every accepted result word with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result word: expected none, actual pixel %08h bounds %0b",
                         $time, o_pixel, o_in_bounds);
            end else begin
                want = pending_results.pop_front();
                if (o_pixel !== want.pixel) begin
                    error_count++;
                    $display("%0t: pixel mismatch: expected %08h, actual %08h",
                             $time, want.pixel, o_pixel);
                end
                if (o_in_bounds !== want.in_bounds) begin
                    error_count++;
                    $display("%0t: in_bounds mismatch: expected %0b, actual %0b",
                             $time, want.in_bounds, o_in_bounds);
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < CANVAS_WORDS; i++)
            canvas_model[i] = TRANSPARENT_PIXEL;
        model_left   = '0;
        model_top    = '0;
        model_width  = DIM_RESET;
        model_height = DIM_RESET;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        // first word waits out the clearing pass on o_in_ready
        test_directed_ops();
        test_config_extremes();
        test_random_traffic();
        wait_idle();
        if (error_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
